// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the PS/2 mouse tracker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ps2 tracker check failed");

// Clocked check that also holds across reset.
`define ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ps2 tracker reset check failed");

`endif

// ----- sv/ps2mt_pkg.sv -----
// Package for the PS/2 mouse packet tracker: codes, byte values, reset values.
// Depends on nothing.
`timescale 1ns / 1ps

package ps2mt_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Command codes of the input word
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_INIT  = 2'd1;
  localparam logic [1:0] CMD_CLAMP = 2'd2;

  // Link modes
  localparam logic [1:0] MODE_RESET  = 2'd0;
  localparam logic [1:0] MODE_ENABLE = 2'd1;
  localparam logic [1:0] MODE_STREAM = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_X  = 2'd0;
  localparam logic [1:0] REG_MAX_Y  = 2'd1;
  localparam logic [1:0] REG_HOME_X = 2'd2;
  localparam logic [1:0] REG_HOME_Y = 2'd3;

  // Protocol bytes
  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
  localparam logic [7:0] BYTE_ENABLE = 8'hF4;
  localparam logic [7:0] BYTE_RESET  = 8'hFF;

  // First packet byte fields
  localparam int SYNC_BIT = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;

  // Register reset values
  localparam int MAX_X_RST  = 319;
  localparam int MAX_Y_RST  = 239;
  localparam int HOME_X_RST = 160;
  localparam int HOME_Y_RST = 120;

  typedef logic [2:0][7:0] window_t;  // [0] oldest byte

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       packet_done;
  } flags_t;

endpackage

// ----- sv/ps2mt_if.sv -----
// Valid/ready channel interfaces for the PS/2 mouse tracker.
// Depends on nothing.
`timescale 1ns / 1ps

interface ps2mt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface ps2mt_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  send_valid;
  logic [7:0]            send_byte;
  logic                  packet_done;
  logic signed [8:0]     delta_x;
  logic signed [8:0]     delta_y;
  logic [2:0]            button_bits;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [1:0]            link_mode;

  modport source (output valid, send_valid, send_byte, packet_done, delta_x, delta_y,
                  button_bits, pos_x, pos_y, link_mode, input ready);
  modport sink   (input valid, send_valid, send_byte, packet_done, delta_x, delta_y,
                  button_bits, pos_x, pos_y, link_mode, output ready);
endinterface

// ----- sv/ps2_mouse_packet_tracker.sv -----
// PS/2 mouse packet tracker top level: input register, state, result register.
// Depends on ps2mt_pkg, ps2mt_in_if, ps2mt_out_if and ps2mt_decode.
// Usage: in_ch carries one word per handshake: cmd (received byte, initialize,
//   re-clamp) and rx_byte. out_ch returns exactly one result word for each
//   input word: the byte to send to the mouse (FF reset or F4 enable), a
//   packet-done flag, the last deltas and buttons, the clamped cursor and
//   the link mode after that word. The cfg port writes max_x, max_y, home_x,
//   home_y by index; write only while no word is in flight.
// Timing: an accepted word lands in the input register, and its result is
//   registered in the result register once that slot is free. One word per
//   cycle is sustained while out_ch.ready stays high: the decode is a single
//   short pass (byte compares, COORD_BITS+2 bit adds and compares).
// Stall: when out_ch.ready is low the result register holds; a word behind
//   it holds in the input register, and in_ch.ready drops only when both
//   registers are full.
// Reset: rst (synchronous) empties both registers, sets the link to the
//   awaiting-reset mode, clears the window and deltas, loads the cursor
//   with 160/120 and the bound registers with their reset values.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ps2mt_in_if.sink              in_ch,
  ps2mt_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  // Input register
  logic       in_full;
  logic [1:0] in_cmd;
  logic [7:0] in_rx;

  // Bound registers
  logic [COORD_BITS-1:0] max_x, max_y, home_x, home_y;

  // Tracker state
  logic [1:0]            mode, mode_next;
  window_t               window, window_next;
  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic signed [8:0]     last_dx, last_dx_next;
  logic signed [8:0]     last_dy, last_dy_next;
  logic [2:0]            last_buttons, last_buttons_next;
  flags_t                flags;

  // Result register
  logic out_full;
  logic advance;

  // Move the held word into the result register when that slot frees up
  assign advance     = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready = !in_full || advance;
  assign out_ch.valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd <= in_ch.cmd;
      in_rx  <= in_ch.rx_byte;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_x  <= COORD_BITS'(MAX_X_RST);
      max_y  <= COORD_BITS'(MAX_Y_RST);
      home_x <= COORD_BITS'(HOME_X_RST);
      home_y <= COORD_BITS'(HOME_Y_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_X:  max_x  <= cfg_data;
        REG_MAX_Y:  max_y  <= cfg_data;
        REG_HOME_X: home_x <= cfg_data;
        REG_HOME_Y: home_y <= cfg_data;
        default: ;
      endcase
    end
  end

  ps2mt_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .cmd               (in_cmd),
    .rx_byte           (in_rx),
    .mode              (mode),
    .window            (window),
    .cursor_x          (cursor_x),
    .cursor_y          (cursor_y),
    .last_dx           (last_dx),
    .last_dy           (last_dy),
    .last_buttons      (last_buttons),
    .max_x             (max_x),
    .max_y             (max_y),
    .home_x            (home_x),
    .home_y            (home_y),
    .mode_next         (mode_next),
    .window_next       (window_next),
    .cursor_x_next     (cursor_x_next),
    .cursor_y_next     (cursor_y_next),
    .last_dx_next      (last_dx_next),
    .last_dy_next      (last_dy_next),
    .last_buttons_next (last_buttons_next),
    .flags             (flags)
  );

  // Commit the state change together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_RESET;
      window       <= '0;
      cursor_x     <= COORD_BITS'(HOME_X_RST);
      cursor_y     <= COORD_BITS'(HOME_Y_RST);
      last_dx      <= '0;
      last_dy      <= '0;
      last_buttons <= '0;
    end else if (advance) begin
      mode         <= mode_next;
      window       <= window_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      last_dx      <= last_dx_next;
      last_dy      <= last_dy_next;
      last_buttons <= last_buttons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  // Result payload; holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.send_valid  <= flags.send_valid;
      out_ch.send_byte   <= flags.send_byte;
      out_ch.packet_done <= flags.packet_done;
      out_ch.delta_x     <= last_dx_next;
      out_ch.delta_y     <= last_dy_next;
      out_ch.button_bits <= last_buttons_next;
      out_ch.pos_x       <= cursor_x_next;
      out_ch.pos_y       <= cursor_y_next;
      out_ch.link_mode   <= mode_next;
    end
  end

endmodule

// ----- sv/ps2mt_decode.sv -----
// Next-state and result logic for one word of the PS/2 mouse tracker.
// Depends on ps2mt_pkg.
`timescale 1ns / 1ps

module ps2mt_decode
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [1:0]            cmd,
  input  logic [7:0]            rx_byte,
  input  logic [1:0]            mode,
  input  window_t               window,
  input  logic [COORD_BITS-1:0] cursor_x,
  input  logic [COORD_BITS-1:0] cursor_y,
  input  logic signed [8:0]     last_dx,
  input  logic signed [8:0]     last_dy,
  input  logic [2:0]            last_buttons,
  input  logic [COORD_BITS-1:0] max_x,
  input  logic [COORD_BITS-1:0] max_y,
  input  logic [COORD_BITS-1:0] home_x,
  input  logic [COORD_BITS-1:0] home_y,
  output logic [1:0]            mode_next,
  output window_t               window_next,
  output logic [COORD_BITS-1:0] cursor_x_next,
  output logic [COORD_BITS-1:0] cursor_y_next,
  output logic signed [8:0]     last_dx_next,
  output logic signed [8:0]     last_dy_next,
  output logic [2:0]            last_buttons_next,
  output flags_t                flags
);

  localparam int SW = COORD_BITS + 2;  // room for cursor plus or minus 256

  logic [7:0]        b1, b2, b3;
  logic              bat_seen;
  logic signed [8:0] dx, dy;
  logic [SW-1:0]     sum_x, sum_y;

  // Clamp a signed sum to 0..hi
  function automatic logic [COORD_BITS-1:0] clamp_sum(input logic [SW-1:0] v,
                                                      input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] r;
    if (v[SW-1]) begin
      r = '0;
    end else if (v > {2'b00, hi}) begin
      r = hi;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign b1 = window[1];
  assign b2 = window[2];
  assign b3 = rx_byte;
  assign bat_seen = (b2 == BYTE_BAT_OK) && (b3 == 8'h00);
  assign dx = {b1[XSIGN_BIT], b2};
  assign dy = {b1[YSIGN_BIT], b3};
  assign sum_x = {2'b00, cursor_x} + {{(SW-9){dx[8]}}, dx};
  assign sum_y = {2'b00, cursor_y} - {{(SW-9){dy[8]}}, dy};

  always_comb begin
    mode_next         = mode;
    window_next       = window;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    last_dx_next      = last_dx;
    last_dy_next      = last_dy;
    last_buttons_next = last_buttons;
    flags             = '0;
    case (cmd)
      CMD_BYTE: begin
        window_next = {b3, b2, b1};
        case (mode)
          MODE_RESET: begin
            if ((b1 == BYTE_ACK) && bat_seen) begin
              mode_next        = MODE_ENABLE;
              flags.send_valid = 1'b1;
              flags.send_byte  = BYTE_ENABLE;
              window_next      = '0;
            end else if (bat_seen) begin
              flags.send_valid = 1'b1;
              flags.send_byte  = BYTE_RESET;
              window_next      = '0;
            end
          end
          MODE_ENABLE: begin
            if (b3 == BYTE_ACK) begin
              mode_next = MODE_STREAM;
            end else begin
              mode_next        = MODE_RESET;
              flags.send_valid = 1'b1;
              flags.send_byte  = BYTE_RESET;
            end
            window_next = '0;
          end
          MODE_STREAM: begin
            if (bat_seen) begin
              mode_next        = MODE_ENABLE;
              flags.send_valid = 1'b1;
              flags.send_byte  = BYTE_ENABLE;
              window_next      = '0;
            end else if (b1[SYNC_BIT]) begin
              last_dx_next      = dx;
              last_dy_next      = dy;
              last_buttons_next = b1[2:0];
              cursor_x_next     = clamp_sum(sum_x, max_x);
              cursor_y_next     = clamp_sum(sum_y, max_y);
              flags.packet_done = 1'b1;
              window_next       = '0;
            end
          end
          default: begin
            mode_next        = MODE_RESET;
            flags.send_valid = 1'b1;
            flags.send_byte  = BYTE_RESET;
            window_next      = '0;
          end
        endcase
      end
      CMD_INIT: begin
        mode_next        = MODE_RESET;
        cursor_x_next    = home_x;
        cursor_y_next    = home_y;
        flags.send_valid = 1'b1;
        flags.send_byte  = BYTE_RESET;
      end
      CMD_CLAMP: begin
        cursor_x_next = (cursor_x > max_x) ? max_x : cursor_x;
        cursor_y_next = (cursor_y > max_y) ? max_y : cursor_y;
      end
      default: begin
        // unused command: report status, change nothing
      end
    endcase
  end

endmodule

// ----- sv/ps2mt_checker.sv -----
// Port-level checks for the PS/2 mouse tracker, bound to the top level.
// Depends on ps2mt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2mt_checker
  import ps2mt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       send_valid,
  input logic [7:0] send_byte,
  input logic       packet_done,
  input logic [1:0] link_mode
);

  // A stalled result stays put
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(send_byte))

  // Nothing comes out right after reset
  `ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid && in_ready)

  // Reset goes with the reset mode, enable with the enable wait
  `ASSERT_CLK(a_send_mode, clk, rst,
              out_valid && send_valid |->
              (send_byte == BYTE_RESET && link_mode == MODE_RESET) ||
              (send_byte == BYTE_ENABLE && link_mode == MODE_ENABLE))

  // Packets complete only while streaming, and never with a command byte
  `ASSERT_CLK(a_packet_stream, clk, rst,
              out_valid && packet_done |-> link_mode == MODE_STREAM && !send_valid)

  // Quiet results carry a zero byte
  `ASSERT_CLK(a_quiet_byte, clk, rst, out_valid && !send_valid |-> send_byte == 8'h00)

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .send_valid  (out_ch.send_valid),
  .send_byte   (out_ch.send_byte),
  .packet_done (out_ch.packet_done),
  .link_mode   (out_ch.link_mode)
);

// ----- bench/tb_ps2_mouse_packet_tracker.sv -----
// Self-checking bench for ps2_mouse_packet_tracker: drives command/byte words,
// predicts every status word in a scoreboard class and compares field by field.
// Depends on ps2mt_pkg, ps2mt_in_if, ps2mt_out_if and the tracker RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  // Command code 3 is unused by the block; it must leave all state alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One status word as the block reports it after each input word.
  typedef struct packed {
    logic          send_valid;
    logic [7:0]    send_byte;
    logic          packet_done;
    logic [8:0]    delta_x;
    logic [8:0]    delta_y;
    logic [2:0]    button_bits;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [1:0]    link_mode;
  } status_t;

  // Tracks link mode, byte window and cursor; queues the status each word should give.
  class tracker_scoreboard;
    logic [CW-1:0] bound_x, bound_y, home_x, home_y;
    logic [1:0]    link;
    logic [7:0]    win [3];  // win[0] is the oldest byte
    int            cur_x, cur_y;
    int            last_dx, last_dy;
    logic [2:0]    last_btn;
    status_t       status_queue [$];
    int            errors;
    int            checked;

    function new();
      bound_x = CW'(MAX_X_RST);
      bound_y = CW'(MAX_Y_RST);
      home_x  = CW'(HOME_X_RST);
      home_y  = CW'(HOME_Y_RST);
      link    = MODE_RESET;
      win     = '{8'h00, 8'h00, 8'h00};
      cur_x   = HOME_X_RST;
      cur_y   = HOME_Y_RST;
      last_dx = 0;
      last_dy = 0;
      last_btn = 3'b000;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_bound(logic [1:0] idx, logic [CW-1:0] v);
      case (idx)
        REG_MAX_X:  bound_x = v;
        REG_MAX_Y:  bound_y = v;
        REG_HOME_X: home_x = v;
        REG_HOME_Y: home_y = v;
        default: ;
      endcase
    endfunction

    function int clamp_to(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void clear_window();
      win = '{8'h00, 8'h00, 8'h00};
    endfunction

    function int pending();
      return status_queue.size();
    endfunction

    // Advance the tracker by one accepted word and queue its status.
    function void note_word(logic [1:0] cmd, logic [7:0] rx);
      status_t want;
      int      dx, dy;
      want = '0;
      case (cmd)
        CMD_BYTE: begin
          win[0] = win[1];
          win[1] = win[2];
          win[2] = rx;
          case (link)
            MODE_RESET: begin
              if (win[0] == BYTE_ACK && win[1] == BYTE_BAT_OK && win[2] == 8'h00) begin
                link = MODE_ENABLE;
                want.send_valid = 1'b1;
                want.send_byte = BYTE_ENABLE;
                clear_window();
              end else if (win[1] == BYTE_BAT_OK && win[2] == 8'h00) begin
                want.send_valid = 1'b1;
                want.send_byte = BYTE_RESET;
                clear_window();
              end
            end
            MODE_ENABLE: begin
              if (win[2] == BYTE_ACK) begin
                link = MODE_STREAM;
              end else begin
                link = MODE_RESET;
                want.send_valid = 1'b1;
                want.send_byte = BYTE_RESET;
              end
              clear_window();
            end
            MODE_STREAM: begin
              if (win[1] == BYTE_BAT_OK && win[2] == 8'h00) begin
                link = MODE_ENABLE;
                want.send_valid = 1'b1;
                want.send_byte = BYTE_ENABLE;
                clear_window();
              end else if (win[0][SYNC_BIT]) begin
                dx = int'(win[1]);
                dy = int'(win[2]);
                if (win[0][XSIGN_BIT]) dx -= 256;
                if (win[0][YSIGN_BIT]) dy -= 256;
                last_dx = dx;
                last_dy = dy;
                last_btn = win[0][2:0];
                cur_x = clamp_to(cur_x + dx, int'(bound_x));
                cur_y = clamp_to(cur_y - dy, int'(bound_y));
                want.packet_done = 1'b1;
                clear_window();
              end
            end
            default: begin
              link = MODE_RESET;
              want.send_valid = 1'b1;
              want.send_byte = BYTE_RESET;
              clear_window();
            end
          endcase
        end
        CMD_INIT: begin
          link = MODE_RESET;
          cur_x = int'(home_x);
          cur_y = int'(home_y);
          want.send_valid = 1'b1;
          want.send_byte = BYTE_RESET;
        end
        CMD_CLAMP: begin
          cur_x = clamp_to(cur_x, int'(bound_x));
          cur_y = clamp_to(cur_y, int'(bound_y));
        end
        default: ;
      endcase
      want.delta_x = last_dx[8:0];
      want.delta_y = last_dy[8:0];
      want.button_bits = last_btn;
      want.pos_x = cur_x[CW-1:0];
      want.pos_y = cur_y[CW-1:0];
      want.link_mode = link;
      status_queue.push_back(want);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_word(status_t got);
      status_t want;
      if (status_queue.size() == 0) begin
        report("status word with nothing pending");
        return;
      end
      want = status_queue.pop_front();
      check_field("send_valid", 16'(got.send_valid), 16'(want.send_valid));
      check_field("send_byte", 16'(got.send_byte), 16'(want.send_byte));
      check_field("packet_done", 16'(got.packet_done), 16'(want.packet_done));
      check_field("delta_x", 16'(got.delta_x), 16'(want.delta_x));
      check_field("delta_y", 16'(got.delta_y), 16'(want.delta_y));
      check_field("button_bits", 16'(got.button_bits), 16'(want.button_bits));
      check_field("pos_x", 16'(got.pos_x), 16'(want.pos_x));
      check_field("pos_y", 16'(got.pos_y), 16'(want.pos_y));
      check_field("link_mode", 16'(got.link_mode), 16'(want.link_mode));
      checked++;
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [CW-1:0] cfg_data;
  logic          sink_ready = 1'b0;

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int words_sent = 0;

  tracker_scoreboard board = new();

  ps2mt_in_if in_ch();
  ps2mt_out_if #(.COORD_BITS(CW)) out_ch();

  ps2_mouse_packet_tracker #(.COORD_BITS(CW)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock, low for the first half period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: stall at random at the rate of the current phase.
  assign out_ch.ready = sink_ready;
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor both channels at the clock edge; values seen here are the
  // pre-edge ones, so each handshake is seen exactly once.
  always @(posedge clk) begin : monitor
    status_t seen;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_word(in_ch.cmd, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen.send_valid  = out_ch.send_valid;
        seen.send_byte   = out_ch.send_byte;
        seen.packet_done = out_ch.packet_done;
        seen.delta_x     = out_ch.delta_x;
        seen.delta_y     = out_ch.delta_y;
        seen.button_bits = out_ch.button_bits;
        seen.pos_x       = out_ch.pos_x;
        seen.pos_y       = out_ch.pos_y;
        seen.link_mode   = out_ch.link_mode;
        board.check_word(seen);
      end
    end
  end

  // Present one word, idling first at the phase rate, and hold it until taken.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] rx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.rx_byte <= rx;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_bytes3(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    send_word(CMD_BYTE, b0);
    send_word(CMD_BYTE, b1);
    send_word(CMD_BYTE, b2);
  endtask

  // Drop valid and wait until every status word has come back, then let
  // the result register settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; drop it after the last.
  task automatic write_reg(input logic [1:0] idx, input logic [CW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    board.set_bound(idx, v);
    @(posedge clk);
  endtask

  task automatic program_bounds(input int mx, input int my, input int hx, input int hy);
    drain();
    write_reg(REG_MAX_X, mx[CW-1:0]);
    write_reg(REG_MAX_Y, my[CW-1:0]);
    write_reg(REG_HOME_X, hx[CW-1:0]);
    write_reg(REG_HOME_Y, hy[CW-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: bring the link up when it is down, then
  // stream packets; mix in noise bytes, reset replies and commands.
  task automatic random_traffic(input int count);
    int         stop_at;
    int         r;
    logic [7:0] head;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (board.link == MODE_RESET && r < 70) begin
        if (r < 8) begin
          send_word(CMD_BYTE, BYTE_BAT_OK);
          send_word(CMD_BYTE, 8'h00);
        end else begin
          send_bytes3(BYTE_ACK, BYTE_BAT_OK, 8'h00);
        end
      end else if (board.link == MODE_ENABLE && r < 70) begin
        send_word(CMD_BYTE, BYTE_ACK);
      end else if (r < 72) begin
        head = 8'($urandom_range(255));
        head[SYNC_BIT] = 1'b1;
        send_bytes3(head, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 80) begin
        send_word(CMD_BYTE, 8'($urandom_range(255)));
      end else if (r < 86) begin
        send_word(CMD_BYTE, BYTE_BAT_OK);
        send_word(CMD_BYTE, 8'h00);
      end else if (r < 91) begin
        send_word(CMD_INIT, 8'($urandom_range(255)));
      end else if (r < 96) begin
        send_word(CMD_CLAMP, 8'($urandom_range(255)));
      end else begin
        send_word(CMD_UNUSED, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MAX_X;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset bounds, no idling on either side.
    // Unused command: status only, nothing moves.
    send_word(CMD_UNUSED, 8'hFF);
    // Bare reset reply without the leading ack: resend reset.
    send_word(CMD_BYTE, BYTE_BAT_OK);
    send_word(CMD_BYTE, 8'h00);
    // Full reset reply: answer with enable, then a wrong ack falls back.
    send_bytes3(BYTE_ACK, BYTE_BAT_OK, 8'h00);
    send_word(CMD_BYTE, 8'h55);
    // Bring the link up to streaming.
    send_bytes3(BYTE_ACK, BYTE_BAT_OK, 8'h00);
    send_word(CMD_BYTE, BYTE_ACK);
    // Largest positive dx with all buttons: clamps at max_x.
    send_bytes3(8'h0F, 8'hFF, 8'h00);
    // Most negative dx and dy: x drops, y clamps at max_y.
    send_bytes3(8'h38, 8'h00, 8'h00);
    // Byte without the sync bit, then a reset reply while streaming.
    send_word(CMD_BYTE, 8'h07);
    send_word(CMD_BYTE, BYTE_BAT_OK);
    send_word(CMD_BYTE, 8'h00);
    // Initialize and re-clamp.
    send_word(CMD_INIT, 8'h00);
    send_word(CMD_CLAMP, 8'hFF);

    // Widest bounds, home at the origin; no idling.
    program_bounds(4095, 4095, 0, 0);
    send_word(CMD_INIT, 8'hA5);
    random_traffic(100);

    // Tightest nonzero bounds, home far outside them; sender mostly idle.
    program_bounds(1, 1, 4095, 4095);
    sender_idle_pct = 85;
    send_word(CMD_INIT, 8'h5A);
    send_word(CMD_CLAMP, 8'h00);
    random_traffic(100);

    // Zero bounds clamp moves to the origin, home outside them; receiver mostly stalled.
    program_bounds(0, 0, 2048, 1);
    sender_idle_pct = 0;
    sink_stall_pct = 85;
    send_word(CMD_INIT, 8'h00);
    random_traffic(100);

    // Random bounds and home; both sides idle now and then.
    program_bounds($urandom_range(4095, 1), $urandom_range(4095, 1),
                   $urandom_range(4095), $urandom_range(4095));
    sender_idle_pct = 36;
    sink_stall_pct = 36;
    send_word(CMD_INIT, 8'hFF);
    random_traffic(100);

    drain();
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
